// ===== rtl/cfp_pkg.sv =====
package cfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = IDX_W + 1;

    localparam logic [7:0] HDR_A       = 8'hAA;
    localparam logic [7:0] HDR_B       = 8'h55;
    localparam logic [7:0] TAIL_SINGLE = 8'h55;
    localparam logic [7:0] TAIL_DOUBLE = 8'hED;

    localparam logic [1:0] REG_TWO_BYTE_HDR = 2'd0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SHOW
    } bk_state_t;

    typedef struct packed {
        logic [7:0]       cmd;
        logic [LEN_W-1:0] len;
        logic             bank;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

// ===== rtl/cfp_front.sv =====
module cfp_front
    import cfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       two_byte_hdr,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output mem_wr_t    mem_wr,
    output logic       push,
    output desc_t      push_desc
);

    phase_t           phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [7:0]       tail_byte;

    assign tail_byte = two_byte_hdr ? TAIL_DOUBLE : TAIL_SINGLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sum_reg   <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        bank_next      = bank_reg;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = {bank_reg, fill_reg[IDX_W-1:0]};
        mem_wr.data    = rx_byte;
        push           = 1'b0;
        push_desc.cmd  = cmd_reg;
        push_desc.len  = len_reg;
        push_desc.bank = bank_reg;
        if (byte_valid) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == HDR_A) begin
                        fill_next = '0;
                        if (two_byte_hdr) begin
                            sum_next   = '0;
                            phase_next = PH_HDR2;
                        end else begin
                            sum_next   = HDR_A;
                            phase_next = PH_CMD;
                        end
                    end
                end
                PH_HDR2: begin
                    phase_next = (rx_byte == HDR_B) ? PH_CMD : PH_IDLE;
                end
                PH_CMD: begin
                    cmd_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    sum_next = sum_reg + rx_byte;
                    if (rx_byte > 8'(MAX_PAYLOAD)) begin
                        phase_next = PH_IDLE;
                    end else begin
                        len_next   = rx_byte[LEN_W-1:0];
                        phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    mem_wr.en = 1'b1;
                    fill_next = fill_reg + LEN_W'(1);
                    sum_next  = sum_reg + rx_byte;
                    if (fill_next >= len_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    phase_next = (sum_reg == rx_byte) ? PH_TAIL : PH_IDLE;
                end
                PH_TAIL: begin
                    if (rx_byte == tail_byte) begin
                        push       = 1'b1;
                        bank_next  = ~bank_reg;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/cfp_queue.sv =====
module cfp_queue
    import cfp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc,
    output logic  full
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // frames pending readout never exceed the two payload banks
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("descriptor queue count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full descriptor queue");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head_valid)
        else $error("pop from empty descriptor queue");

    // a new frame must land in the bank not held by the head
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && head_valid) |-> (push_desc.bank != head_desc.bank))
        else $error("new frame reuses a bank still awaiting readout");

endmodule

// ===== rtl/cfp_back.sv =====
module cfp_back
    import cfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_wr_t           mem_wr,
    input  logic              head_valid,
    input  desc_t             head_desc,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        command,
    output logic [LEN_W-1:0]  frame_len,
    output logic              has_data,
    output logic [IDX_W-1:0]  byte_index,
    output logic [7:0]        data_byte,
    output logic              last
);

    localparam int DEPTH = 2 * MAX_PAYLOAD;

    logic [7:0]       payload_mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    bk_state_t        state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign rd_addr = {head_desc.bank, idx_reg};

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            payload_mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= payload_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign command    = head_desc.cmd;
    assign frame_len  = head_desc.len;
    assign has_data   = (head_desc.len != '0);
    assign byte_index = idx_reg;
    assign data_byte  = has_data ? rd_data_reg : 8'd0;
    assign last       = !has_data || ((LEN_W'(idx_reg) + LEN_W'(1)) == head_desc.len);
    assign res_valid  = (state_reg == BK_SHOW);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                idx_next = '0;
                if (head_valid) begin
                    state_next = (head_desc.len == '0) ? BK_SHOW : BK_FETCH;
                end
            end
            BK_FETCH: begin
                state_next = BK_SHOW;
            end
            BK_SHOW: begin
                if (res_ready) begin
                    if (last) begin
                        pop        = 1'b1;
                        idx_next   = '0;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/checksummed_frame_parser.sv =====
// channel   | ports                  | payload
// ----------+------------------------+-------------------------------------------
// input     | s_tvalid/s_tready      | s_tdata: rx_byte
// output    | m_tvalid/m_tready      | m_tdata, m_tuser: has_data, m_tlast: last
// register  | apb psel/penable/...   | 0x0: two_byte_hdr
//
// the parser takes one byte per cycle; it holds s_tready low only while two
// completed frames await readout, one in each payload bank
// a data result passes a payload memory read in BK_FETCH and is then shown in BK_SHOW;
// each frame passes the idle state ahead of it, and an empty frame has no read
// reset is synchronous, active low; the payload memory has no reset
// stalls on m_tready hold the result and let the parser keep filling the free bank
module checksummed_frame_parser
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] command, [14:8] frame_len, [20:15] byte_index,
                                   // [28:21] data_byte, [31:29] zero
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             two_byte_hdr_reg, two_byte_hdr_next;
    logic             q_full;
    logic             byte_valid;
    mem_wr_t          mem_wr;
    logic             push;
    desc_t            push_desc;
    logic             pop;
    logic             head_valid;
    desc_t            head_desc;
    logic [7:0]       command;
    logic [LEN_W-1:0] frame_len;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       data_byte;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TWO_BYTE_HDR[0]);

    always_comb begin
        two_byte_hdr_next = two_byte_hdr_reg;
        if (cfg_write) begin
            two_byte_hdr_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            two_byte_hdr_reg <= 1'b0;
        end else begin
            two_byte_hdr_reg <= two_byte_hdr_next;
        end
    end

    assign prdata = (paddr[2] == REG_TWO_BYTE_HDR[0]) ? {31'd0, two_byte_hdr_reg} : 32'd0;

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    cfp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .two_byte_hdr  (two_byte_hdr_reg),
        .byte_valid    (byte_valid),
        .rx_byte       (s_tdata),
        .mem_wr        (mem_wr),
        .push          (push),
        .push_desc     (push_desc)
    );

    cfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .full       (q_full)
    );

    cfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mem_wr     (mem_wr),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .command    (command),
        .frame_len  (frame_len),
        .has_data   (m_tuser),
        .byte_index (byte_index),
        .data_byte  (data_byte),
        .last       (m_tlast)
    );

    assign m_tdata = {3'd0, data_byte, byte_index, frame_len, command};

endmodule
